### rtl/neh_pkg.sv
// neh_pkg: constants, register indexes and helpers for the event histogram
// no dependencies; imported by the interfaces and the top level
package neh_pkg;

  localparam int MAX_BINS   = 32;
  localparam int COUNT_BITS = 20;
  localparam int POINT_BITS = 20;

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int N_W   = $clog2(MAX_BINS + 1);
  localparam int J_W   = $clog2(MAX_BINS + 3);
  localparam int SUM_W = COUNT_BITS + $clog2(MAX_BINS + 1);
  localparam int DVS_W = (SUM_W > 31) ? SUM_W : 31;
  localparam int DIV_W = COUNT_BITS + 32;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // configuration register indexes
  localparam logic [2:0] REG_LOWER   = 3'd0;
  localparam logic [2:0] REG_WIDTH   = 3'd1;
  localparam logic [2:0] REG_INVERSE = 3'd2;
  localparam logic [2:0] REG_BINS    = 3'd3;
  localparam logic [2:0] REG_NORM    = 3'd4;
  localparam logic [2:0] REG_SIDES   = 3'd5;
  localparam logic [2:0] REG_OVERLAP = 3'd6;

  // commands
  localparam logic [1:0] CMD_EVENT  = 2'd0;
  localparam logic [1:0] CMD_REF    = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // normalisation modes
  localparam logic [1:0] NORM_NONE = 2'd0;
  localparam logic [1:0] NORM_PEAK = 2'd1;
  localparam logic [1:0] NORM_AREA = 2'd2;
  localparam logic [1:0] NORM_SUM  = 2'd3;

  // saturate a wide value to 32 bits
  function automatic logic [31:0] sat32(input logic [DIV_W-1:0] v);
    if (v[DIV_W-1:32] != '0) begin
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

endpackage

### rtl/neh_if.sv
// neh_if: valid/ready channels for input items and result items
// depends on neh_pkg for field widths
interface neh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] sample;
  modport source (output valid, cmd, sample, input ready);
  modport sink   (input valid, cmd, sample, output ready);
endinterface

interface neh_out_if;
  logic                           valid;
  logic                           ready;
  logic [5:0]                     bin_number;
  logic [31:0]                    bin_center;
  logic [31:0]                    frequency;
  logic [31:0]                    overlap_value;
  logic [neh_pkg::POINT_BITS-1:0] points_binned;
  logic                           last;
  modport source (output valid, bin_number, bin_center, frequency, overlap_value,
                  points_binned, last, input ready);
  modport sink   (input valid, bin_number, bin_center, frequency, overlap_value,
                  points_binned, last, output ready);
endinterface

### rtl/normalized_event_histogram_unit.sv
// normalized_event_histogram_unit: event and reference histograms with a
// shared restoring divider for normalisation; depends on neh_pkg and neh_if
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    cmd, sample
//   results   out  valid/ready    bin_number, bin_center, frequency,
//                                 overlap_value, points_binned, last
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// a sample steps through difference, 32x32 multiply and count update;
// a clear-reference item clears the reference counts when accepted
// a finish scans the bins in use for peak and sum, then per bin divides
// (twice in area mode, not when raw), then waits for the output handshake
// reset clears all counts and configuration registers; ready is low while busy
module normalized_event_histogram_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  neh_in_if.sink           samples,
  neh_out_if.source        results
);
  import neh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_BIN, S_UPD, S_SCAN, S_PREP, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [31:0] lower_limit;
  logic [30:0] bin_width;
  logic [31:0] inverse_width;
  logic [5:0]  bin_count;
  logic [1:0]  normalize_mode;
  logic        add_sides;
  logic        overlap_enable;

  // stores
  logic [COUNT_BITS-1:0] event_counts [MAX_BINS];
  logic [COUNT_BITS-1:0] reference_counts [MAX_BINS];
  logic [POINT_BITS-1:0] event_points;

  // working registers
  logic [1:0]            cmd_q;
  logic [32:0]           diff;
  logic [63:0]           prod;
  logic                  neg;
  logic [J_W-1:0]        j;
  logic [COUNT_BITS-1:0] peak;
  logic [SUM_W-1:0]      sum;
  logic [31:0]           center;
  logic [DIV_W-1:0]      dq;
  logic [DVS_W-1:0]      rem;
  logic [DVS_W-1:0]      dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  second;
  logic [31:0]           freq;

  // output registers
  logic        out_valid;
  logic [5:0]  out_bin;
  logic [31:0] out_center;
  logic [31:0] out_freq;
  logic [31:0] out_ovl;
  logic [POINT_BITS-1:0] out_points;
  logic        out_last;

  // bins in use
  logic [N_W-1:0] n_used;
  always_comb begin
    if (bin_count == 6'd0) begin
      n_used = N_W'(1);
    end else if (32'(bin_count) > 32'(MAX_BINS)) begin
      n_used = N_W'(MAX_BINS);
    end else begin
      n_used = N_W'(bin_count);
    end
  end

  // bin lookup from registered product
  logic [IDX_W-1:0] hit_idx;
  logic             hit;
  always_comb begin
    if (neg) begin
      hit_idx = '0;
      hit     = (inverse_width == 32'd0);
    end else begin
      hit_idx = prod[32 +: IDX_W];
      hit     = (prod[63:32] < 32'(n_used));
    end
  end

  // emission bin position
  logic [J_W-1:0]   k;
  logic             in_range;
  logic [IDX_W-1:0] k_idx;
  logic [J_W-1:0]   total;
  assign k        = j - J_W'(add_sides);
  assign in_range = (j >= J_W'(add_sides)) && (k < J_W'(n_used));
  assign k_idx    = k[IDX_W-1:0];
  assign total    = J_W'(n_used) + (add_sides ? J_W'(2) : J_W'(0));

  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] cur_ref;
  assign cur_count = event_counts[k_idx];
  assign cur_ref   = reference_counts[k_idx];

  logic [DIV_W-1:0] raw_wide;
  logic [DIV_W-1:0] ref_wide;
  assign raw_wide = DIV_W'(cur_count) << 16;
  assign ref_wide = DIV_W'(cur_ref) << 16;

  // normaliser is zero, keep raw
  logic norm_zero;
  always_comb begin
    case (normalize_mode)
      NORM_PEAK: norm_zero = (peak == '0);
      NORM_AREA: norm_zero = (sum == '0) || (bin_width == 31'd0);
      NORM_SUM:  norm_zero = (sum == '0);
      default:   norm_zero = 1'b1;
    endcase
  end

  // one restoring divider step
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_next;
  assign trial    = {rem, dq[DIV_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];

  logic [31:0] ref_sat;
  assign ref_sat = sat32(ref_wide);

  assign samples.ready         = (state == S_IDLE);
  assign results.valid         = out_valid;
  assign results.bin_number    = out_bin;
  assign results.bin_center    = out_center;
  assign results.frequency     = out_freq;
  assign results.overlap_value = out_ovl;
  assign results.points_binned = out_points;
  assign results.last          = out_last;

  logic [32:0] smp_ext;
  logic [32:0] low_ext;
  assign smp_ext = {samples.sample[31], samples.sample};
  assign low_ext = {lower_limit[31], lower_limit};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      lower_limit    <= 32'd0;
      bin_width      <= 31'd65536;
      inverse_width  <= 32'd65536;
      bin_count      <= 6'd20;
      normalize_mode <= NORM_NONE;
      add_sides      <= 1'b0;
      overlap_enable <= 1'b0;
      event_points   <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < MAX_BINS; i++) begin
        event_counts[i]     <= '0;
        reference_counts[i] <= '0;
      end
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_LOWER:   lower_limit    <= cfg_data;
          REG_WIDTH:   bin_width      <= cfg_data[30:0];
          REG_INVERSE: inverse_width  <= cfg_data;
          REG_BINS:    bin_count      <= cfg_data[5:0];
          REG_NORM:    normalize_mode <= cfg_data[1:0];
          REG_SIDES:   add_sides      <= cfg_data[0];
          REG_OVERLAP: overlap_enable <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            cmd_q <= samples.cmd;
            diff  <= smp_ext - low_ext;
            case (samples.cmd)
              CMD_CLEAR: begin
                for (int i = 0; i < MAX_BINS; i++) begin
                  reference_counts[i] <= '0;
                end
              end
              CMD_FINISH: begin
                j      <= '0;
                peak   <= '0;
                sum    <= '0;
                center <= lower_limit + {2'b0, bin_width[30:1]}
                          - (add_sides ? {1'b0, bin_width} : 32'd0);
                state  <= S_SCAN;
              end
              default: state <= S_BIN;
            endcase
          end
        end
        S_BIN: begin
          neg   <= diff[32];
          prod  <= diff[31:0] * inverse_width;
          state <= S_UPD;
        end
        S_UPD: begin
          if (hit) begin
            if (cmd_q == CMD_EVENT) begin
              if (event_counts[hit_idx] != '1) begin
                event_counts[hit_idx] <= event_counts[hit_idx] + 1'b1;
              end
              if (event_points != '1) begin
                event_points <= event_points + 1'b1;
              end
            end else if (reference_counts[hit_idx] != '1) begin
              reference_counts[hit_idx] <= reference_counts[hit_idx] + 1'b1;
            end
          end
          state <= S_IDLE;
        end
        // peak and sum over bins in use
        S_SCAN: begin
          if (event_counts[j[IDX_W-1:0]] > peak) begin
            peak <= event_counts[j[IDX_W-1:0]];
          end
          sum <= sum + SUM_W'(event_counts[j[IDX_W-1:0]]);
          if (j == J_W'(n_used) - 1'b1) begin
            j     <= '0;
            state <= S_PREP;
          end else begin
            j <= j + 1'b1;
          end
        end
        // pick raw, zero or divider path
        S_PREP: begin
          second <= 1'b0;
          rem    <= '0;
          cnt    <= CNT_W'(DIV_W);
          if (!in_range) begin
            freq  <= 32'd0;
            state <= S_FIN;
          end else if (norm_zero) begin
            freq  <= sat32(raw_wide);
            state <= S_FIN;
          end else begin
            case (normalize_mode)
              NORM_PEAK: begin
                dq  <= raw_wide;
                dvs <= DVS_W'(peak);
              end
              NORM_AREA: begin
                dq  <= DIV_W'(cur_count) << 32;
                dvs <= DVS_W'(sum);
              end
              default: begin
                dq  <= raw_wide;
                dvs <= DVS_W'(sum);
              end
            endcase
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt != '0) begin
            rem <= rem_next;
            dq  <= {dq[DIV_W-2:0], ge};
            cnt <= cnt - 1'b1;
          end else if (normalize_mode == NORM_AREA && !second) begin
            second <= 1'b1;
            rem    <= '0;
            dvs    <= DVS_W'(bin_width);
            cnt    <= CNT_W'(DIV_W);
          end else begin
            freq  <= sat32(dq);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid  <= 1'b1;
          out_bin    <= j[5:0];
          out_center <= center;
          out_freq   <= freq;
          out_ovl    <= (overlap_enable && in_range)
                        ? ((freq < ref_sat) ? freq : ref_sat) : 32'd0;
          out_points <= event_points;
          out_last   <= (j + 1'b1 == total);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            center    <= center + {1'b0, bin_width};
            j         <= j + 1'b1;
            if (out_last) begin
              event_points <= '0;
              for (int i = 0; i < MAX_BINS; i++) begin
                event_counts[i] <= '0;
              end
              state <= S_IDLE;
            end else begin
              state <= S_PREP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/tb_channels.sv
// tb_channels: the expected result beat type; the channel interfaces come from rtl/neh_if.sv
// kept so the testbench file list mirrors the rtl layout; depends on neh_pkg
`timescale 1ns / 1ps
package tb_channels_pkg;
  import neh_pkg::*;
  // one expected result beat
  typedef struct packed {
    logic [5:0]            bin_number;
    logic [31:0]           bin_center;
    logic [31:0]           frequency;
    logic [31:0]           overlap_value;
    logic [POINT_BITS-1:0] points_binned;
    logic                  last;
  } bin_result_t;
endpackage

### tb/tb.sv
// tb: checks the event histogram against an in-bench predictor of binning,
// normalisation and overlap; random gaps on both channels; needs neh_pkg, neh_if
`timescale 1ns / 1ps
module tb;
  import neh_pkg::*;
  import tb_channels_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  neh_in_if  samples();
  neh_out_if results();

  normalized_event_histogram_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .samples(samples), .results(results)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] lower_q, inv_q;
  logic [30:0] width_q;
  logic [5:0]  bins_q;
  logic [1:0]  norm_q;
  logic        sides_q, overlap_q;
  logic [63:0] ev_count [MAX_BINS];
  logic [63:0] ref_count [MAX_BINS];
  logic [19:0] ev_points;

  bin_result_t pending_bins[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_ready_high = 0;

  initial begin
    samples.valid = 1'b0;
    samples.cmd = '0;
    samples.sample = '0;
    results.ready = 1'b0;
  end

  function automatic int used_bins();
    if (bins_q < 1) return 1;
    if (bins_q > MAX_BINS) return MAX_BINS;
    return bins_q;
  endfunction

  // bin index of a sample, -1 when dropped
  function automatic int locate_bin(logic [31:0] s);
    longint diff;
    logic [63:0] d, idx;
    diff = longint'($signed(s)) - longint'($signed(lower_q));
    if (diff < 0) return (inv_q == 0) ? 0 : -1;
    d = diff;
    idx = d[63:32] * inv_q + ((d[31:0] * inv_q) >> 32);
    if (idx >= used_bins()) return -1;
    return int'(idx);
  endfunction

  function automatic logic [63:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic logic [63:0] scaled_count(logic [63:0] c, logic [63:0] pk,
                                               logic [63:0] tot);
    if (norm_q == NORM_PEAK && pk != 0) return clip32((c << 16) / pk);
    if (norm_q == NORM_AREA && tot != 0 && width_q != 0)
      return clip32(((c << 32) / tot) / width_q);
    if (norm_q == NORM_SUM && tot != 0) return clip32((c << 16) / tot);
    return clip32(c << 16);
  endfunction

  // apply one accepted beat to the predictor
  task automatic predict_histogram(logic [1:0] cmd, logic [31:0] s);
    int b, n, total;
    logic [63:0] pk, tot, center, f, r, o;
    bin_result_t e;
    pk = 0; tot = 0;
    if (cmd == CMD_EVENT || cmd == CMD_REF) begin
      b = locate_bin(s);
      if (b >= 0) begin
        if (cmd == CMD_EVENT) begin
          if (ev_count[b] < (64'd1 << COUNT_BITS) - 1) ev_count[b]++;
          if (ev_points != 20'hFFFFF) ev_points++;
        end else if (ref_count[b] < (64'd1 << COUNT_BITS) - 1) begin
          ref_count[b]++;
        end
      end
    end else if (cmd == CMD_CLEAR) begin
      foreach (ref_count[i]) ref_count[i] = 0;
    end else begin
      n = used_bins();
      for (int j = 0; j < n; j++) begin
        if (ev_count[j] > pk) pk = ev_count[j];
        tot += ev_count[j];
      end
      total = n + (sides_q ? 2 : 0);
      center = {32'd0, lower_q} + (width_q >> 1);
      if (sides_q) center -= width_q;
      for (int j = 0; j < total; j++) begin
        int k;
        k = sides_q ? j - 1 : j;
        f = 0; o = 0;
        if (k >= 0 && k < n) begin
          f = scaled_count(ev_count[k], pk, tot);
          r = clip32(ref_count[k] << 16);
          if (overlap_q) o = (f < r) ? f : r;
        end
        e.bin_number = j[5:0];
        e.bin_center = center[31:0];
        e.frequency = f[31:0];
        e.overlap_value = o[31:0];
        e.points_binned = ev_points;
        e.last = (j + 1 == total);
        pending_bins.push_back(e);
        center += width_q;
      end
      foreach (ev_count[i]) ev_count[i] = 0;
      ev_points = 0;
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // send one beat and predict it; valid drops at the start of a gap
  task automatic send_beat(logic [1:0] cmd, logic [31:0] s);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.cmd <= cmd;
    samples.sample <= s;
    do @(posedge clk); while (!samples.ready);
    predict_histogram(cmd, s);
  endtask

  // wait for every result, then let a sample in flight settle
  task automatic drain_results();
    samples.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOWER:   lower_q = v;
      REG_WIDTH:   width_q = v[30:0];
      REG_INVERSE: inv_q = v;
      REG_BINS:    bins_q = v[5:0];
      REG_NORM:    norm_q = v[1:0];
      REG_SIDES:   sides_q = v[0];
      REG_OVERLAP: overlap_q = v[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_layout(logic [31:0] lo, logic [31:0] w, logic [31:0] inv,
                            logic [5:0] n, logic [1:0] nm, bit sd, bit ov);
    drain_results();
    write_reg(REG_LOWER, lo);
    write_reg(REG_WIDTH, w);
    write_reg(REG_INVERSE, inv);
    write_reg(REG_BINS, {26'd0, n});
    write_reg(REG_NORM, {30'd0, nm});
    write_reg(REG_SIDES, {31'd0, sd});
    write_reg(REG_OVERLAP, {31'd0, ov});
  endtask

  // result ready with random stalls
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_ready_high) begin
      results.ready <= 1'b1;
    end else begin
      results.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 :
                       ($urandom_range(0, 3) != 0);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    bin_result_t e;
    if (!rst) begin
      if (results.valid && results.ready) begin
        if (pending_bins.size() == 0) begin
          $error("unexpected result beat, bin_number %0d", results.bin_number);
          errors++;
        end else begin
          e = pending_bins.pop_front();
          if (results.bin_number !== e.bin_number) begin
            $error("bin_number exp %0d got %0d", e.bin_number, results.bin_number);
            errors++;
          end
          if (results.bin_center !== e.bin_center) begin
            $error("bin_center exp %h got %h", e.bin_center, results.bin_center);
            errors++;
          end
          if (results.frequency !== e.frequency) begin
            $error("frequency exp %h got %h", e.frequency, results.frequency);
            errors++;
          end
          if (results.overlap_value !== e.overlap_value) begin
            $error("overlap_value exp %h got %h", e.overlap_value,
                   results.overlap_value);
            errors++;
          end
          if (results.points_binned !== e.points_binned) begin
            $error("points_binned exp %0d got %0d", e.points_binned,
                   results.points_binned);
            errors++;
          end
          if (results.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, results.last);
            errors++;
          end
        end
      end
      if ((results.valid && results.ready) || (samples.valid && samples.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // field extremes and every command under default registers, then edge-case layouts
  task automatic test_directed();
    send_beat(CMD_EVENT, 32'h0000_0000);
    send_beat(CMD_EVENT, 32'h0013_FFFF);
    send_beat(CMD_EVENT, 32'h0014_0000);
    send_beat(CMD_EVENT, 32'h8000_0000);
    send_beat(CMD_EVENT, 32'h7FFF_FFFF);
    send_beat(CMD_EVENT, 32'hFFFF_FFFF);
    send_beat(CMD_REF, 32'h0000_8000);
    send_beat(CMD_REF, 32'h0005_0000);
    send_beat(CMD_FINISH, rand_word());
    send_beat(CMD_FINISH, rand_word());
    send_beat(CMD_CLEAR, 32'hFFFF_FFFF);
    // zero inverse width sends everything to bin 0
    set_layout(32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 6'd1, NORM_PEAK, 1'b1, 1'b1);
    send_beat(CMD_EVENT, 32'h8000_0000);
    send_beat(CMD_REF, 32'h7FFF_FFFF);
    send_beat(CMD_FINISH, 32'h0);
    // many bins, sides, area norm, zero-width area fallback
    set_layout(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 6'd63, NORM_AREA, 1'b1, 1'b1);
    send_beat(CMD_EVENT, 32'h8000_0000);
    send_beat(CMD_EVENT, 32'h8000_0001);
    send_beat(CMD_FINISH, 32'h0);
    set_layout(32'hFFF0_0000, 32'h0000_0001, 32'h0000_0010, 6'd0, NORM_SUM,
               1'b0, 1'b1);
    send_beat(CMD_EVENT, 32'h0);
    send_beat(CMD_REF, 32'h0);
    send_beat(CMD_FINISH, 32'h0);
  endtask

  // counts left above a reduced bin count are dropped by the finish
  task automatic test_reduced_bins();
    set_layout(32'h0, 32'h0001_0000, 32'h0001_0000, 6'd8, NORM_NONE, 1'b0, 1'b0);
    send_beat(CMD_EVENT, 32'h0007_0000);
    drain_results();
    write_reg(REG_BINS, 32'd4);
    send_beat(CMD_EVENT, 32'h0001_0000);
    send_beat(CMD_FINISH, 32'h0);
    drain_results();
  endtask

  // random layouts, mostly in-range samples, finish every so often
  task automatic test_random_runs();
    int sent;
    logic [31:0] lo, w, s;
    int n;
    sent = 0;
    while (sent < 140) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 33) : $urandom_range(1, 8);
      lo = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 32'h0004_0000)
           - 32'h0002_0000;
      w = $urandom_range(1, 4) << 15;
      set_layout(lo, ($urandom_range(0, 9) == 0) ? rand_word() : w,
                 (32'h8000_0000 / w) << 1, n[5:0], 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) send_beat(CMD_CLEAR, rand_word());
      repeat ($urandom_range(4, 20)) begin
        if ($urandom_range(0, 9) == 0)
          s = rand_word();
        else
          s = lo + $urandom_range(0, n * w + w);
        send_beat($urandom_range(0, 3) == 0 ? CMD_REF : CMD_EVENT, s);
        sent++;
      end
      send_beat(CMD_FINISH, rand_word());
      sent++;
      // pressure: let the whole run drain before carrying on
      if ($urandom_range(0, 3) == 0) drain_results();
    end
  endtask

  // back-to-back with ready held high
  task automatic test_no_stall();
    hold_ready_high = 1;
    set_layout(32'h0, 32'h0001_0000, 32'h0001_0000, 6'd4, NORM_PEAK, 1'b0, 1'b1);
    for (int i = 0; i < 12; i++) begin
      samples.valid <= 1'b1;
      samples.cmd <= (i == 11) ? CMD_FINISH : CMD_EVENT;
      samples.sample <= $urandom_range(0, 32'h0004_FFFF);
      do @(posedge clk); while (!samples.ready);
      predict_histogram(samples.cmd, samples.sample);
    end
    drain_results();
    hold_ready_high = 0;
  endtask

  initial begin
    lower_q = 0; width_q = 31'h10000; inv_q = 32'h10000; bins_q = 20;
    norm_q = NORM_NONE; sides_q = 0; overlap_q = 0; ev_points = 0;
    foreach (ev_count[i]) begin
      ev_count[i] = 0;
      ref_count[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_reduced_bins();
    test_random_runs();
    test_no_stall();
    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_bins.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
